### hw/rtl/nso_pkg.sv
// Package for the Newton step optimizer: widths, payload structs, codes and
// saturation helpers. Used by every module in hw/rtl.
package nso_pkg;

	localparam int WORD_BITS_DEF  = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TRIAL_BITS_DEF = 16;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [CFG_IDX_BITS-1:0] REG_STEP_SIZE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIAL_LIM  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_GOAL_MODE  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONS_MODE  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_CMP_OP     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONS_BOUND = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_INIT_POINT = 3'd7;

	localparam logic [2:0] ST_EVALUATE   = 3'd0;
	localparam logic [2:0] ST_SETTLED    = 3'd1;
	localparam logic [2:0] ST_TRIAL_LIM  = 3'd2;
	localparam logic [2:0] ST_BAD_OBJ    = 3'd3;
	localparam logic [2:0] ST_ZERO_CURV  = 3'd4;
	localparam logic [2:0] ST_NO_MIN     = 3'd5;
	localparam logic [2:0] ST_NO_MAX     = 3'd6;

	localparam logic [1:0] GOAL_MIN = 2'd1;
	localparam logic [1:0] GOAL_MAX = 2'd2;
	localparam logic [1:0] CONS_VAR = 2'd1;
	localparam logic [1:0] CONS_MEAS = 2'd2;

	localparam logic [2:0] CMP_LT = 3'd0;
	localparam logic [2:0] CMP_LE = 3'd1;
	localparam logic [2:0] CMP_EQ = 3'd2;
	localparam logic [2:0] CMP_NE = 3'd3;
	localparam logic [2:0] CMP_GE = 3'd4;
	localparam logic [2:0] CMP_GT = 3'd5;

	typedef struct packed {
		logic               start_timestep;
		logic signed [31:0] objective_value;
		logic               objective_bad;
		logic signed [31:0] constraint_measure;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] variable_value;
		logic [2:0]         status;
		logic [15:0]        iteration_count;
	} out_item_t;

	// Saturate a signed 34-bit value to 32 bits.
	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v > 34'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (v < -34'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic cmp_holds(input logic [2:0] op,
		input logic signed [31:0] m, input logic signed [31:0] b);
		case (op)
			CMP_LT:  return m < b;
			CMP_LE:  return m <= b;
			CMP_EQ:  return m == b;
			CMP_NE:  return m != b;
			CMP_GE:  return m >= b;
			CMP_GT:  return m > b;
			default: return 1'b1;
		endcase
	endfunction

endpackage

### hw/rtl/nso_div.sv
// Serial signed fixed-point divider, one quotient bit per cycle, saturating.
// Depends on nso_pkg.
module nso_div import nso_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	output logic               done,
	output logic signed [31:0] quo
);
	localparam int QB = 32 + FRAC_BITS;
	localparam int CB = $clog2(QB + 1);

	logic [QB-1:0] dvd_q;
	logic [QB-1:0] q_q;
	logic [32:0]   r_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic [32:0]   r_sh;
	logic [32:0]   lim;

	assign r_sh = {r_q[31:0], dvd_q[QB-1]};
	assign lim  = neg_q ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CB'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
			den_q <= den[31] ? 32'(-den) : 32'(den);
			neg_q <= num[31] ^ den[31];
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (r_sh >= {1'b0, den_q}) begin
				r_q <= r_sh - {1'b0, den_q};
				q_q <= {q_q[QB-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[QB-2:0], 1'b0};
			end
		end
	end

	logic [32:0] qm;
	always_comb begin
		if (q_q[QB-1:32] != '0) begin
			qm = lim;
		end else if ({1'b0, q_q[31:0]} > lim) begin
			qm = lim;
		end else begin
			qm = {1'b0, q_q[31:0]};
		end
		quo = neg_q ? 32'(-qm) : qm[31:0];
	end
endmodule

### hw/rtl/newton_step_optimizer_top.sv
// Top level of the Newton step optimizer: handshake, configuration,
// sequencer and state. Depends on nso_pkg and nso_div.
// A stop or settle report is registered directly from idle, a probe goes through S_PRB, the
// second probe objective needs one division and a Newton step three in the serial nso_div.
// One item at a time; input stalls until the result transfer.
// Reset (arst_n low) clears control state and restores register defaults.
module newton_step_optimizer_top import nso_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_D1   = 4'd1;
	localparam logic [3:0] S_D2   = 4'd2;
	localparam logic [3:0] S_D3   = 4'd3;
	localparam logic [3:0] S_DEC  = 4'd4;
	localparam logic [3:0] S_D4   = 4'd5;
	localparam logic [3:0] S_CONS = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;
	localparam logic [3:0] S_WAIT = 4'd8;
	localparam logic [3:0] S_PRB  = 4'd9;

	logic [30:0] step_q, tol_q;
	logic [15:0] tlim_q;
	logic [1:0]  goal_q, cmode_q;
	logic [2:0]  op_q;
	logic signed [31:0] bound_q, init_q;

	logic [3:0]  st_q;
	logic [1:0]  phase_q;
	logic [15:0] trials_q;
	logic signed [31:0] base_q, cand_q, pobj_q, pslope_q, soff_q;
	logic signed [31:0] y_q, d2_q, ddy_q, dy_q, meas_q;
	out_item_t   out_q;

	logic signed [31:0] dl;
	assign dl = (step_q == '0) ? 32'sd1 : $signed({1'b0, step_q});
	logic signed [31:0] tol;
	assign tol = $signed({1'b0, tol_q});

	logic               dv_start, dv_done;
	logic signed [31:0] dv_num, dv_den, dv_q;

	nso_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.done(dv_done), .quo(dv_q)
	);

	logic take;
	assign in_stall  = (st_q != S_IDLE);
	assign take      = in_valid && !in_stall;
	assign out_valid = (st_q == S_WAIT);
	assign out_data  = out_q;

	logic signed [31:0] p_minus, p_plus, dy_sum;
	assign p_minus = sat34(34'(cand_q) - 34'(dl));
	assign p_plus  = sat34(34'(cand_q) + 34'(dl));
	logic signed [31:0] dsum;
	assign dsum    = sat34(34'(d2_q) + 34'(pslope_q));
	assign dy_sum  = dsum / 32'sd2;
	logic [31:0] dy_mag;
	assign dy_mag  = dy_q[31] ? 32'(-dy_q) : 32'(dy_q);
	logic [15:0] iters;
	assign iters = trials_q;
	logic signed [31:0] diff_y;
	assign diff_y = sat34(34'(y_q) - 34'(pobj_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 31'd65536; tol_q <= 31'd66; tlim_q <= '0; goal_q <= '0;
			cmode_q <= '0; op_q <= '0; bound_q <= '0; init_q <= '0;
			st_q <= S_IDLE; phase_q <= '0; trials_q <= '0;
			base_q <= '0; cand_q <= '0; pobj_q <= '0; pslope_q <= '0; soff_q <= '0;
			dv_start <= 1'b0;
		end else begin
			dv_start <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx)
					REG_STEP_SIZE:  step_q  <= cfg_data[30:0];
					REG_TOLERANCE:  tol_q   <= cfg_data[30:0];
					REG_TRIAL_LIM:  tlim_q  <= cfg_data[15:0];
					REG_GOAL_MODE:  goal_q  <= cfg_data[1:0];
					REG_CONS_MODE:  cmode_q <= cfg_data[1:0];
					REG_CMP_OP:     op_q    <= cfg_data[2:0];
					REG_CONS_BOUND: bound_q <= cfg_data;
					REG_INIT_POINT: begin
						init_q <= cfg_data; base_q <= cfg_data; cand_q <= cfg_data;
					end
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (take) begin
					y_q <= in_data.objective_value;
					meas_q <= in_data.constraint_measure;
					if (in_data.start_timestep) begin
						soff_q <= '0;
						st_q <= S_PRB;
					end else if (tlim_q != '0 && trials_q > tlim_q) begin
						out_q <= '{base_q, ST_TRIAL_LIM, iters};
						st_q <= S_WAIT;
					end else if (in_data.objective_bad) begin
						out_q <= '{base_q, ST_BAD_OBJ, iters};
						st_q <= S_WAIT;
					end else begin
						case (phase_q)
							2'd0: begin
								pobj_q <= in_data.objective_value;
								phase_q <= 2'd1;
								st_q <= S_PRB;
							end
							2'd1: begin
								dv_num <= sat34(34'(in_data.objective_value) - 34'(pobj_q));
								dv_den <= dl;
								dv_start <= 1'b1;
								st_q <= S_D1;
							end
							2'd2: begin
								dv_num <= sat34(34'(in_data.objective_value) - 34'(pobj_q));
								dv_den <= dl;
								dv_start <= 1'b1;
								st_q <= S_D2;
							end
							default: begin
								phase_q <= 2'd0;
								out_q <= '{cand_q, ST_SETTLED, iters};
								st_q <= S_WAIT;
							end
						endcase
					end
				end
				S_D1: if (dv_done) begin
					pslope_q <= dv_q;
					pobj_q <= y_q;
					phase_q <= 2'd2;
					st_q <= S_PRB;
				end
				S_D2: if (dv_done) begin
					d2_q <= dv_q;
					dv_num <= sat34(34'(dv_q) - 34'(pslope_q));
					dv_den <= dl;
					dv_start <= 1'b1;
					st_q <= S_D3;
				end
				S_D3: if (dv_done) begin
					ddy_q <= dv_q;
					dy_q <= dy_sum;
					st_q <= S_DEC;
				end
				S_DEC: begin
					if (dy_mag < {1'b0, tol_q}) begin
						phase_q <= 2'd3;
						if (trials_q != '1) trials_q <= trials_q + 1'b1;
						st_q <= S_OUT;
					end else if (ddy_q == '0) begin
						out_q <= '{base_q, ST_ZERO_CURV, iters}; st_q <= S_WAIT;
					end else if (ddy_q < 0 && goal_q == GOAL_MIN) begin
						out_q <= '{base_q, ST_NO_MIN, iters}; st_q <= S_WAIT;
					end else if (ddy_q > 0 && goal_q == GOAL_MAX) begin
						out_q <= '{base_q, ST_NO_MAX, iters}; st_q <= S_WAIT;
					end else begin
						dv_num <= dy_q; dv_den <= ddy_q; dv_start <= 1'b1;
						st_q <= S_D4;
					end
				end
				S_D4: if (dv_done) begin
					d2_q <= dv_q;
					cand_q <= sat34(34'(base_q) - 34'(dv_q));
					phase_q <= 2'd0;
					st_q <= S_CONS;
				end
				S_CONS: begin
					if (cmode_q == CONS_VAR || cmode_q == CONS_MEAS) begin
						if (soff_q > 0 && soff_q < tol) begin
							phase_q <= 2'd3;
						end else if (cmode_q == CONS_VAR) begin
							if (!cmp_holds(op_q, cand_q, bound_q)) begin
								cand_q <= bound_q; phase_q <= 2'd3;
							end
						end else if (!cmp_holds(op_q, meas_q, bound_q)) begin
							if (soff_q != '0) begin
								soff_q <= soff_q / 32'sd2;
								cand_q <= sat34(34'(base_q) + 34'(soff_q / 32'sd2));
							end else begin
								soff_q <= sat34(34'sd0 - 34'(d2_q));
								cand_q <= sat34(34'(base_q) + 34'(sat34(34'sd0 - 34'(d2_q))));
							end
						end else if (soff_q != '0) begin
							soff_q <= soff_q / 32'sd2;
							cand_q <= sat34(34'(base_q) - 34'(soff_q / 32'sd2));
						end
					end
					if (trials_q != '1) trials_q <= trials_q + 1'b1;
					st_q <= S_OUT;
				end
				S_OUT, S_PRB: begin
					case (phase_q)
						2'd0: begin
							base_q <= cand_q;
							out_q <= '{p_minus, ST_EVALUATE, iters};
						end
						2'd1: out_q <= '{cand_q, ST_EVALUATE, iters};
						2'd2: out_q <= '{p_plus, ST_EVALUATE, iters};
						default: out_q <= '{cand_q, ST_SETTLED, iters};
					endcase
					st_q <= S_WAIT;
				end
				S_WAIT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = ^{init_q, diff_y};

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> !take) else $error("item taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dv_start |-> (st_q == S_D1 || st_q == S_D2 || st_q == S_D3 || st_q == S_D4))
		else $error("divider started outside a divide state");
endmodule

### tb/sv/newton_step_optimizer_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for newton_step_optimizer_top: an in-bench predictor of the
// Newton search checks every output transfer. Depends on nso_pkg and the RTL in hw/rtl.

module newton_step_optimizer_top_tb;
	import nso_pkg::*;

	class newton_scoreboard;
		longint unsigned step_reg, tol_reg, lim_reg, goal_reg, cons_reg, cmp_reg;
		longint bound_reg;
		int unsigned phase;
		longint unsigned trials;
		longint base_pt, cand_pt, prev_obj, prev_slope, offset;
		longint last_point;
		out_item_t expected_q[$];
		int errors;

		function new();
			step_reg = 65536; tol_reg = 66; lim_reg = 0; goal_reg = 0;
			cons_reg = 0; cmp_reg = 0; bound_reg = 0;
			phase = 0; trials = 0; base_pt = 0; cand_pt = 0;
			prev_obj = 0; prev_slope = 0; offset = 0; last_point = 0; errors = 0;
		endfunction

		function longint clampw(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint fixdiv(longint a, longint b);
			longint unsigned ua, ub, q, r, lim;
			bit neg, sat;
			ua = a < 0 ? -a : a;
			ub = b < 0 ? -b : b;
			neg = (a < 0) != (b < 0);
			sat = 0;
			lim = neg ? 64'd2147483648 : 64'd2147483647;
			q = ua / ub;
			r = ua % ub;
			for (int i = 0; i < 16 && !sat; i++) begin
				if (q > lim / 2) begin
					sat = 1;
				end else begin
					q = q << 1;
					r = r << 1;
					if (r >= ub) begin
						r -= ub;
						q++;
					end
				end
			end
			if (sat || q > lim) q = lim;
			return neg ? -longint'(q) : longint'(q);
		endfunction

		function bit holds(longint m, longint b);
			case (cmp_reg[2:0])
				CMP_LT: return m < b;
				CMP_LE: return m <= b;
				CMP_EQ: return m == b;
				CMP_NE: return m != b;
				CMP_GE: return m >= b;
				CMP_GT: return m > b;
				default: return 1'b1;
			endcase
		endfunction

		function longint delta();
			return step_reg != 0 ? longint'(step_reg) : 64'sd1;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
			case (idx)
				REG_STEP_SIZE:  step_reg = val[30:0];
				REG_TOLERANCE:  tol_reg = val[30:0];
				REG_TRIAL_LIM:  lim_reg = val[15:0];
				REG_GOAL_MODE:  goal_reg = val[1:0];
				REG_CONS_MODE:  cons_reg = val[1:0];
				REG_CMP_OP:     cmp_reg = val[2:0];
				REG_CONS_BOUND: bound_reg = longint'($signed(val));
				REG_INIT_POINT: begin
					base_pt = longint'($signed(val));
					cand_pt = base_pt;
				end
				default: ;
			endcase
		endfunction

		function void emit(longint v, logic [2:0] st);
			out_item_t o;
			o.variable_value = v[31:0];
			o.status = st;
			o.iteration_count = trials > 65535 ? 16'hFFFF : trials[15:0];
			last_point = v;
			expected_q.push_back(o);
		endfunction

		function void emit_probe();
			case (phase)
				0: begin
					base_pt = cand_pt;
					emit(clampw(cand_pt - delta()), ST_EVALUATE);
				end
				1: emit(cand_pt, ST_EVALUATE);
				2: emit(clampw(cand_pt + delta()), ST_EVALUATE);
				default: emit(cand_pt, ST_SETTLED);
			endcase
		endfunction

		function void note_input(in_item_t it);
			longint y, d2, ddy, dy, stp, tol, meas;
			tol = longint'(tol_reg);
			if (it.start_timestep) begin
				offset = 0;
				emit_probe();
				return;
			end
			if (lim_reg > 0 && trials > lim_reg) begin
				emit(base_pt, ST_TRIAL_LIM);
				return;
			end
			if (it.objective_bad) begin
				emit(base_pt, ST_BAD_OBJ);
				return;
			end
			y = longint'(it.objective_value);
			case (phase)
				0: begin
					prev_obj = y;
					phase = 1;
					emit_probe();
					return;
				end
				1: begin
					prev_slope = fixdiv(clampw(y - prev_obj), delta());
					prev_obj = y;
					phase = 2;
					emit_probe();
					return;
				end
				2: ;
				default: begin
					phase = 0;
					emit(cand_pt, ST_SETTLED);
					return;
				end
			endcase
			d2 = fixdiv(clampw(y - prev_obj), delta());
			ddy = fixdiv(clampw(d2 - prev_slope), delta());
			dy = clampw(d2 + prev_slope) / 2;
			if ((dy < 0 ? -dy : dy) < tol) begin
				phase = 3;
			end else begin
				if (ddy == 0) begin
					emit(base_pt, ST_ZERO_CURV);
					return;
				end
				if (ddy < 0 && goal_reg == GOAL_MIN) begin
					emit(base_pt, ST_NO_MIN);
					return;
				end
				if (ddy > 0 && goal_reg == GOAL_MAX) begin
					emit(base_pt, ST_NO_MAX);
					return;
				end
				stp = fixdiv(dy, ddy);
				cand_pt = clampw(base_pt - stp);
				phase = 0;
				meas = longint'(it.constraint_measure);
				if (cons_reg == CONS_VAR || cons_reg == CONS_MEAS) begin
					if (offset > 0 && offset < tol) begin
						phase = 3;
					end else if (cons_reg == CONS_VAR) begin
						if (!holds(cand_pt, bound_reg)) begin
							cand_pt = bound_reg;
							phase = 3;
						end
					end else if (!holds(meas, bound_reg)) begin
						if (offset != 0) offset = offset / 2;
						else offset = clampw(-stp);
						cand_pt = clampw(base_pt + offset);
					end else if (offset != 0) begin
						offset = offset / 2;
						cand_pt = clampw(base_pt - offset);
					end
				end
			end
			if (trials < 65535) trials++;
			emit_probe();
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transfer: %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got.variable_value !== want.variable_value || got.status !== want.status ||
			    got.iteration_count !== want.iteration_count) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected var %h st %0d it %0d, got var %h st %0d it %0d",
						want.variable_value, want.status, want.iteration_count,
						got.variable_value, got.status, got.iteration_count);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [CFG_IDX_BITS-1:0] cfg_idx;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	in_item_t in_data;
	out_item_t out_data;

	newton_scoreboard sb;
	int send_idle_pct, recv_idle_pct, quiet_cycles, hold_left;
	bit hold_go;
	longint fn_center, fn_curv, fn_lin, fn_offs;

	newton_step_optimizer_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall) sb.check_result(out_data);
		if (hold_go) begin
			hold_go = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("FAIL newton_step_optimizer_top");
			$finish;
		end
	end

	task automatic send(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && !in_stall));
		sb.note_input(it);
	endtask

	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic configure(logic [31:0] stp, logic [31:0] tol, logic [15:0] lim,
		logic [1:0] goal, logic [1:0] cons, logic [2:0] cmp, logic [31:0] bnd,
		logic [31:0] init);
		drain();
		cfg_write(REG_STEP_SIZE, stp);
		cfg_write(REG_TOLERANCE, tol);
		cfg_write(REG_TRIAL_LIM, {16'd0, lim});
		cfg_write(REG_GOAL_MODE, {30'd0, goal});
		cfg_write(REG_CONS_MODE, {30'd0, cons});
		cfg_write(REG_CMP_OP, {29'd0, cmp});
		cfg_write(REG_CONS_BOUND, bnd);
		cfg_write(REG_INIT_POINT, init);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] objective_at(longint x);
		longint d, sq, y;
		d = x - fn_center;
		if (d > 64'sd8388608) d = 64'sd8388608;
		if (d < -64'sd8388608) d = -64'sd8388608;
		sq = (d * d) >>> 16;
		y = ((fn_curv * sq) >>> 16) + ((fn_lin * d) >>> 16) + fn_offs;
		y = sb.clampw(y);
		return y[31:0];
	endfunction

	function automatic void new_objective();
		fn_center = $signed($urandom_range(1 << 22)) - (1 << 21);
		fn_curv = ($urandom_range(3) == 0) ? 0 : $signed($urandom_range(1 << 18)) - (1 << 17);
		fn_lin = ($urandom_range(1) == 0) ? 0 : $signed($urandom_range(1 << 20)) - (1 << 19);
		fn_offs = $signed($urandom_range(1 << 20)) - (1 << 19);
	endfunction

	function automatic in_item_t objective_item(bit bad);
		in_item_t it;
		it.start_timestep = 1'b0;
		it.objective_value = objective_at(sb.last_point);
		it.objective_bad = bad;
		case ($urandom_range(3))
			0: it.constraint_measure = sb.bound_reg[31:0];
			1: it.constraint_measure = $urandom();
			default: it.constraint_measure = sb.bound_reg[31:0] + $urandom_range(131072) - 65536;
		endcase
		return it;
	endfunction

	task automatic run_phase(int n, bit with_hold);
		in_item_t it;
		int r;
		new_objective();
		it = objective_item(0);
		it.start_timestep = 1'b1;
		send(it);
		for (int i = 0; i < n; i++) begin
			if (i < n / 3) begin
				send_idle_pct = 18;
				recv_idle_pct = 61;
			end else if (i < 2 * n / 3) begin
				send_idle_pct = 61;
				recv_idle_pct = 18;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (with_hold && i == n / 2) hold_go = 1;
			if (i % 40 == 39) new_objective();
			r = $urandom_range(99);
			if (r < 8) begin
				it = objective_item(0);
				it.start_timestep = 1'b1;
			end else if (r < 14) begin
				it = 66'({$urandom(), $urandom(), $urandom()});
			end else begin
				it = objective_item($urandom_range(49) == 0);
			end
			send(it);
		end
	endtask

	initial begin
		in_item_t it;
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		hold_go = 0;
		quiet_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset defaults: a full search on a bowl, then edge values.
		fn_center = 3 <<< 16;
		fn_curv = 65536;
		fn_lin = 0;
		fn_offs = 0;
		it = objective_item(0);
		send(it);
		it.start_timestep = 1'b1;
		send(it);
		for (int i = 0; i < 10; i++) send(objective_item(0));
		send(objective_item(1));
		it = objective_item(0);
		it.objective_value = 32'h7FFF_FFFF;
		it.constraint_measure = 32'h8000_0000;
		send(it);
		it.objective_value = 32'h8000_0000;
		it.constraint_measure = 32'h7FFF_FFFF;
		send(it);
		it.start_timestep = 1'b1;
		send(it);
		it = '1;
		send(it);
		it = '0;
		send(it);

		configure(32'd0, 32'd1, 16'd0, 2'd0, CONS_VAR, CMP_LT, 32'h0001_0000, 32'h8000_0000);
		run_phase(150, 0);
		configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, GOAL_MIN, 2'd0, CMP_LE, 32'h8000_0000,
			32'h7FFF_FFFF);
		run_phase(100, 0);
		configure(32'd65536, 32'd66, 16'd0, GOAL_MIN, CONS_MEAS, CMP_GE, 32'd0, 32'd0);
		run_phase(200, 1);
		configure(32'd4096, 32'd16, 16'd0, GOAL_MAX, CONS_VAR, CMP_GT, 32'hFFFF_0000, 32'd0);
		run_phase(150, 0);
		configure(32'd1, 32'd1, 16'd0, 2'd3, CONS_MEAS, CMP_EQ, 32'h7FFF_FFFF, 32'h0002_0000);
		run_phase(150, 0);
		configure(32'd32768, 32'd300, 16'd0, 2'd0, CONS_MEAS, CMP_NE, 32'd0, 32'hFFFE_0000);
		run_phase(150, 0);
		configure(32'd131072, 32'd66, 16'd0, GOAL_MIN, CONS_VAR, CMP_GE, 32'h0001_8000, 32'd0);
		run_phase(150, 0);
		configure(32'd65536, 32'd100, 16'd0, 2'd0, CONS_MEAS, 3'd6, 32'd0, 32'd0);
		run_phase(100, 0);
		configure(32'd65536, 32'd100, 16'd0, 2'd0, 2'd3, 3'd7, 32'd0, 32'd0);
		run_phase(100, 0);
		configure(32'd200000, 32'd50, 16'd65535, GOAL_MAX, CONS_MEAS, CMP_LT, 32'd12345, 32'd0);
		run_phase(150, 0);
		configure(32'd65536, 32'd66, 16'd1, 2'd0, CONS_VAR, CMP_LE, 32'h0010_0000, 32'd0);
		run_phase(150, 0);
		configure(32'd65536, 32'd66, 16'd0, 2'd0, CONS_MEAS, CMP_GT, 32'hFFF0_0000, 32'd0);
		run_phase(150, 1);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("PASS newton_step_optimizer_top");
		end else begin
			$display("FAIL newton_step_optimizer_top");
		end
		$finish;
	end

endmodule
